FILE: src/deadline_ordered_timer_queue_macros.svh
// Assertion macros for the deadline-ordered timer queue checker.
// Needs nothing else; included by the checker file only.
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DOTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue check failed");

// Next-cycle implication, disabled during reset.
`define DOTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue check failed");

`endif

FILE: src/dotq_pkg.sv
// Shared types and codes for the deadline-ordered timer queue.
// No dependencies; imported by the top level, the cell, the checker and the bench.
`default_nettype none

package dotq_pkg;

    localparam logic [2:0] OP_POST    = 3'd0;
    localparam logic [2:0] OP_CANCEL  = 3'd1;
    localparam logic [2:0] OP_POP_ONE = 3'd2;
    localparam logic [2:0] OP_POP_ALL = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;

    localparam logic [1:0] KIND_POST_ACK   = 2'd0;
    localparam logic [1:0] KIND_CANCEL_ACK = 2'd1;
    localparam logic [1:0] KIND_FIRED      = 2'd2;
    localparam logic [1:0] KIND_DONE       = 2'd3;

    // Per-cycle command broadcast to every cell of the chain.
    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_INSERT = 3'd1;
    localparam logic [2:0] CELL_SHIFT  = 3'd2;
    localparam logic [2:0] CELL_MARK   = 3'd3;
    localparam logic [2:0] CELL_RIPPLE = 3'd4;
    localparam logic [2:0] CELL_REMOVE = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] now_tick;
        logic [31:0] delay_ticks;
        logic [15:0] task_handle;
        logic [31:0] cancel_id;
    } t_request;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] result_id;
        logic [15:0] fired_handle;
        logic        cancel_found;
        logic        queue_full;
        logic        wakeup_valid;
        logic [63:0] wakeup_time;
        logic        last;
    } t_result;

    // Sort key: deadline first, id breaks ties.
    typedef struct packed {
        logic [63:0] deadline;
        logic [31:0] id;
    } t_key;

    typedef struct packed {
        logic [2:0]  op;
        t_key        new_key;
        logic [31:0] cancel_id;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: src/deadline_ordered_timer_queue.sv
// Top level of the deadline-ordered timer queue: sequencer plus a chain of slots.
// Depends on dotq_pkg and dotq_cell.
//
// Usage:
//   Present a request on i_request and raise start; it is taken at a clock
//   edge where start is high and busy is low. Results come out on o_result,
//   each for exactly one cycle with o_result_valid high; the receiver cannot
//   stall them, so sample every strobe. The result flagged last closes the
//   request.
// Steps per request:
//   stop, unused codes, pops while stopped and refused posts (stopped or
//     full): 1 result, registered as the request is taken, no busy time.
//   accepted post: add and id are registered, then the parallel insert.
//   cancel: matching slots are marked as the request is taken, the mark
//     ripples one slot per cycle down the chain, then marked slots close up.
//   pop: take the request, fire due heads in turn (pop-one at most one), then
//     the closing result; fired tasks strobe back to back.
// Reset (synchronous, active low) empties the queue, clears the id counter
// and the stop flag; slot contents are left as they are and only the first
// entry-count slots are ever looked at.
`default_nettype none

module deadline_ordered_timer_queue
    import dotq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_request i_request,
    output logic          busy,
    output logic          o_result_valid,
    output t_result       o_result
);

    // Handle bits kept per slot; the request field is 16 bits wide.
    localparam int HW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_POST   = 3'd1;
    localparam logic [2:0] S_RIPPLE = 3'd2;
    localparam logic [2:0] S_REMOVE = 3'd3;
    localparam logic [2:0] S_POP    = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_id_ctr, n_id_ctr;
    logic          r_stopped, n_stopped;
    logic [SW-1:0] r_step, n_step;
    logic          r_fired, n_fired;
    logic          r_valid, n_valid;

    logic [63:0]   r_dl, n_dl;
    logic [31:0]   r_id, n_id;
    logic [HW-1:0] r_handle, n_handle;
    logic [63:0]   r_now, n_now;
    logic          r_all, n_all;
    t_result       r_result, n_result;

    logic          w_accept;
    logic [64:0]   w_sum;
    logic [63:0]   w_dl;
    logic [31:0]   w_id_inc;
    logic [31:0]   w_next_id;
    logic          w_due;
    t_cell_ctl     w_ctl;

    t_key          w_key    [DEPTH];
    logic [HW-1:0] w_hnd    [DEPTH];
    logic          w_lt     [DEPTH];
    logic          w_del    [DEPTH];
    logic          w_occ    [DEPTH];

    assign w_accept = start && (r_state == S_IDLE);

    // Saturating deadline and next id (zero is never handed out).
    assign w_sum     = {1'b0, i_request.now_tick} + {33'b0, i_request.delay_ticks};
    assign w_dl      = w_sum[64] ? '1 : w_sum[63:0];
    assign w_id_inc  = r_id_ctr + 32'd1;
    assign w_next_id = (w_id_inc == 32'd0) ? 32'd1 : w_id_inc;

    // Head fires if due; pop-one fires at most once.
    assign w_due = (r_count != '0) && (w_key[0].deadline <= r_now) && (r_all || !r_fired);

    // Chain of slots; slot 0 is the head.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_key          w_left_key;
        logic [HW-1:0] w_left_hnd;
        logic          w_left_lt;
        logic          w_left_del;
        t_key          w_right_key;
        logic [HW-1:0] w_right_hnd;

        assign w_occ[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_left_key = '0;
            assign w_left_hnd = '0;
            assign w_left_lt  = 1'b1;
            assign w_left_del = 1'b0;
        end else begin : g_body
            assign w_left_key = w_key[g-1];
            assign w_left_hnd = w_hnd[g-1];
            assign w_left_lt  = w_lt[g-1];
            assign w_left_del = w_del[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_key = '0;
            assign w_right_hnd = '0;
        end else begin : g_inner
            assign w_right_key = w_key[g+1];
            assign w_right_hnd = w_hnd[g+1];
        end

        dotq_cell #(
            .HW (HW)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_new_handle   (r_handle),
            .i_occ          (w_occ[g]),
            .i_left_key     (w_left_key),
            .i_left_handle  (w_left_hnd),
            .i_left_lt      (w_left_lt),
            .i_left_del     (w_left_del),
            .i_right_key    (w_right_key),
            .i_right_handle (w_right_hnd),
            .o_key          (w_key[g]),
            .o_handle       (w_hnd[g]),
            .o_lt           (w_lt[g]),
            .o_del          (w_del[g])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_id_ctr  = r_id_ctr;
        n_stopped = r_stopped;
        n_step    = r_step;
        n_fired   = r_fired;
        n_valid   = 1'b0;
        n_dl      = r_dl;
        n_id      = r_id;
        n_handle  = r_handle;
        n_now     = r_now;
        n_all     = r_all;
        n_result  = r_result;

        w_ctl.op        = CELL_HOLD;
        w_ctl.new_key   = '{deadline: r_dl, id: r_id};
        w_ctl.cancel_id = i_request.cancel_id;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_request.opcode) inside
                        OP_POST: begin
                            if (r_stopped || (r_count == CW'(DEPTH))) begin
                                // Refuse: answer at once, id counter untouched.
                                n_valid             = 1'b1;
                                n_result            = '0;
                                n_result.kind       = KIND_POST_ACK;
                                n_result.queue_full = !r_stopped;
                                n_result.last       = 1'b1;
                            end else begin
                                n_dl     = w_dl;
                                n_id     = w_next_id;
                                n_id_ctr = w_next_id;
                                n_handle = HW'(i_request.task_handle);
                                n_state  = S_POST;
                            end
                        end
                        OP_CANCEL: begin
                            // Mark matching slots now, spread the mark next.
                            w_ctl.op = CELL_MARK;
                            n_step   = '0;
                            n_state  = S_RIPPLE;
                        end
                        OP_POP_ONE, OP_POP_ALL: begin
                            if (r_stopped) begin
                                n_valid       = 1'b1;
                                n_result      = '0;
                                n_result.kind = KIND_DONE;
                                n_result.last = 1'b1;
                            end else begin
                                n_now   = i_request.now_tick;
                                n_all   = (i_request.opcode == OP_POP_ALL);
                                n_fired = 1'b0;
                                n_state = S_POP;
                            end
                        end
                        default: begin
                            // Stop, or a code with no meaning: just close.
                            if (i_request.opcode == OP_STOP) begin
                                n_stopped = 1'b1;
                            end
                            n_valid       = 1'b1;
                            n_result      = '0;
                            n_result.kind = KIND_DONE;
                            n_result.last = 1'b1;
                        end
                    endcase
                end
            end
            S_POST: begin
                // All slots decide in parallel: keep, take new, or shift right.
                w_ctl.op              = CELL_INSERT;
                n_count               = r_count + CW'(1);
                n_valid               = 1'b1;
                n_result              = '0;
                n_result.kind         = KIND_POST_ACK;
                n_result.result_id    = r_id;
                n_result.wakeup_valid = (r_count == '0) || (r_dl < w_key[0].deadline);
                n_result.wakeup_time  = ((r_count == '0) || (r_dl < w_key[0].deadline))
                                        ? r_dl : 64'd0;
                n_result.last         = 1'b1;
                n_state               = S_IDLE;
            end
            S_RIPPLE: begin
                // Advance the mark one slot per cycle so every slot past the
                // first match ends up marked.
                w_ctl.op = CELL_RIPPLE;
                n_step   = r_step + SW'(1);
                if (r_step == SW'(DEPTH - 2)) begin
                    n_state = S_REMOVE;
                end
            end
            S_REMOVE: begin
                // Marked slots pull from the right, closing the gap.
                w_ctl.op              = CELL_REMOVE;
                if (w_del[DEPTH-1]) begin
                    n_count = r_count - CW'(1);
                end
                n_valid               = 1'b1;
                n_result              = '0;
                n_result.kind         = KIND_CANCEL_ACK;
                n_result.cancel_found = w_del[DEPTH-1];
                n_result.last         = 1'b1;
                n_state               = S_IDLE;
            end
            S_POP: begin
                n_valid  = 1'b1;
                n_result = '0;
                if (w_due) begin
                    // Fire the head and drop it from the chain.
                    w_ctl.op              = CELL_SHIFT;
                    n_count               = r_count - CW'(1);
                    n_fired               = 1'b1;
                    n_result.kind         = KIND_FIRED;
                    n_result.result_id    = w_key[0].id;
                    n_result.fired_handle = 16'(w_hnd[0]);
                end else begin
                    n_result.kind         = KIND_DONE;
                    n_result.wakeup_valid = (r_count != '0);
                    n_result.wakeup_time  = (r_count != '0) ? w_key[0].deadline : 64'd0;
                    n_result.last         = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_id_ctr  <= '0;
            r_stopped <= 1'b0;
            r_step    <= '0;
            r_fired   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_id_ctr  <= n_id_ctr;
            r_stopped <= n_stopped;
            r_step    <= n_step;
            r_fired   <= n_fired;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl     <= n_dl;
        r_id     <= n_id;
        r_handle <= n_handle;
        r_now    <= n_now;
        r_all    <= n_all;
        r_result <= n_result;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_result       = r_result;

endmodule

`default_nettype wire

FILE: src/dotq_cell.sv
// One slot of the sorted chain: key, handle and a removal mark.
// Depends on dotq_pkg; instantiated DEPTH times by the top level.
`default_nettype none

module dotq_cell
    import dotq_pkg::*;
#(
    parameter int HW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cell_ctl     i_ctl,
    input  wire logic [HW-1:0] i_new_handle,
    input  wire logic          i_occ,
    input  wire t_key          i_left_key,
    input  wire logic [HW-1:0] i_left_handle,
    input  wire logic          i_left_lt,
    input  wire logic          i_left_del,
    input  wire t_key          i_right_key,
    input  wire logic [HW-1:0] i_right_handle,
    output t_key               o_key,
    output logic [HW-1:0]      o_handle,
    output logic               o_lt,
    output logic               o_del
);

    t_key          r_key, n_key;
    logic [HW-1:0] r_handle, n_handle;
    logic          r_del, n_del;
    logic          w_lt;

    // Occupied slot ordered strictly ahead of the incoming key.
    assign w_lt = i_occ && ({r_key.deadline, r_key.id} <
                            {i_ctl.new_key.deadline, i_ctl.new_key.id});

    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        n_del    = r_del;
        unique case (i_ctl.op)
            CELL_INSERT: begin
                if (!w_lt) begin
                    if (i_left_lt) begin
                        n_key    = i_ctl.new_key;
                        n_handle = i_new_handle;
                    end else begin
                        n_key    = i_left_key;
                        n_handle = i_left_handle;
                    end
                end
            end
            CELL_SHIFT: begin
                n_key    = i_right_key;
                n_handle = i_right_handle;
            end
            CELL_MARK: begin
                n_del = i_occ && (r_key.id == i_ctl.cancel_id);
            end
            CELL_RIPPLE: begin
                n_del = r_del | i_left_del;
            end
            CELL_REMOVE: begin
                if (r_del) begin
                    n_key    = i_right_key;
                    n_handle = i_right_handle;
                end
                n_del = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_del <= 1'b0;
        end else begin
            r_del <= n_del;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

    assign o_key    = r_key;
    assign o_handle = r_handle;
    assign o_lt     = w_lt;
    assign o_del    = r_del;

endmodule

`default_nettype wire

FILE: src/dotq_checker.sv
// Port-level checks for the deadline-ordered timer queue, bound to the top level.
// Depends on dotq_pkg and deadline_ordered_timer_queue_macros.svh.
`default_nettype none

`include "deadline_ordered_timer_queue_macros.svh"

module dotq_checker
    import dotq_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     o_result_valid,
    input wire t_result  o_result
);

    // A taken request either answers next cycle or keeps the block busy.
    `DOTQ_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_result_valid)

    // A pop streams fired tasks back to back until its closing result.
    `DOTQ_ASSERT_NEXT(a_stream_continues, i_clk, i_rst_n, o_result_valid && !o_result.last, o_result_valid)

    // After the closing result the block is idle unless a new request arrives.
    `DOTQ_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, o_result_valid && o_result.last && !start, !busy)

    // A post refused as full carries no id and asks for no wakeup.
    `DOTQ_ASSERT_NOW(a_full_no_id, i_clk, i_rst_n, o_result_valid && (o_result.kind == KIND_POST_ACK) && o_result.queue_full, (o_result.result_id == 32'd0) && !o_result.wakeup_valid)

endmodule

bind deadline_ordered_timer_queue dotq_checker u_dotq_checker (.*);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for deadline_ordered_timer_queue: directed and random requests.
// Depends on dotq_pkg; keeps a shadow copy of the queue to predict every reply.

module testbench;
    import dotq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int HANDLE_BITS  = 16;
    localparam int RANDOM_ITEMS = 110;
    localparam int CYCLE_LIMIT  = 200000;
    // A pop-all that fires every slot is the slowest request.
    localparam int TAIL_CYCLES  = DEPTH + 8;
    localparam int PRINT_CAP    = 200;
    localparam logic [15:0] HANDLE_MASK = 16'((64'd1 << HANDLE_BITS) - 1);
    localparam logic [63:0] TICK_MAX    = '1;
    localparam logic [31:0] DELAY_MAX   = '1;
    // Codes the block leaves unused: it answers them with a bare done reply.
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

    logic     i_clk;
    logic     i_rst_n   = 1'b0;
    logic     start     = 1'b0;
    t_request i_request = '0;
    logic     busy;
    logic     o_result_valid;
    t_result  o_result;

    deadline_ordered_timer_queue #(
        .DEPTH      (DEPTH),
        .HANDLE_BITS(HANDLE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_request     (i_request),
        .busy          (busy),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    // Shadow copy of the queue, head at index 0.
    logic [63:0] shadow_deadline [DEPTH];
    logic [31:0] shadow_id       [DEPTH];
    logic [15:0] shadow_handle   [DEPTH];
    int unsigned shadow_count   = 0;
    logic [31:0] shadow_last_id = '0;
    bit          shadow_stopped = 1'b0;

    // Replies the block still owes, oldest first.
    t_result owed_replies[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    // Idle cycles before the next request goes out, and whether start is up now.
    int next_gap       = 0;
    bit start_raised   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Bound the run: a hung block must not hang the bench.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies owed", cycle_count,
                     owed_replies.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch %0s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // Append one owed reply; the wakeup time reads zero unless a wakeup is asked.
    function automatic void owe_reply(logic [1:0] kind, logic [31:0] id, logic [15:0] handle,
                                      bit found, bit full, bit wake, logic [63:0] wake_at,
                                      bit last);
        t_result r;
        r.kind         = kind;
        r.result_id    = id;
        r.fired_handle = handle;
        r.cancel_found = found;
        r.queue_full   = full;
        r.wakeup_valid = wake;
        r.wakeup_time  = wake ? wake_at : 64'd0;
        r.last         = last;
        owed_replies.insert(owed_replies.size(), r);
    endfunction

    // Close the gap left by the entry at pos.
    function automatic void drop_shadow_entry(int unsigned pos);
        for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
            shadow_deadline[i] = shadow_deadline[i + 1];
            shadow_id[i]       = shadow_id[i + 1];
            shadow_handle[i]   = shadow_handle[i + 1];
        end
        shadow_count--;
    endfunction

    // Apply one accepted request to the shadow queue and owe its replies.
    function automatic void update_shadow_queue(t_request req);
        logic [64:0] sum;
        logic [63:0] deadline;
        logic [31:0] fresh_id;
        int unsigned pos;
        bit          wake;
        bit          found;
        case (req.opcode) inside
            OP_POST: begin
                if (shadow_stopped) begin
                    owe_reply(KIND_POST_ACK, '0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
                end else if (shadow_count >= DEPTH) begin
                    owe_reply(KIND_POST_ACK, '0, '0, 1'b0, 1'b1, 1'b0, '0, 1'b1);
                end else begin
                    // Saturate the deadline instead of wrapping past the top tick.
                    sum      = {1'b0, req.now_tick} + {33'd0, req.delay_ticks};
                    deadline = sum[64] ? TICK_MAX : sum[63:0];
                    // Skip id 0 when the counter wraps.
                    fresh_id = shadow_last_id + 32'd1;
                    if (fresh_id == 32'd0)
                        fresh_id = 32'd1;
                    shadow_last_id = fresh_id;
                    wake = (shadow_count == 0) || (deadline < shadow_deadline[0]);
                    pos  = 0;
                    while (pos < shadow_count &&
                           (shadow_deadline[pos] < deadline ||
                            (shadow_deadline[pos] == deadline && shadow_id[pos] < fresh_id)))
                        pos++;
                    for (int unsigned i = shadow_count; i > pos; i--) begin
                        shadow_deadline[i] = shadow_deadline[i - 1];
                        shadow_id[i]       = shadow_id[i - 1];
                        shadow_handle[i]   = shadow_handle[i - 1];
                    end
                    shadow_deadline[pos] = deadline;
                    shadow_id[pos]       = fresh_id;
                    shadow_handle[pos]   = req.task_handle & HANDLE_MASK;
                    shadow_count++;
                    owe_reply(KIND_POST_ACK, fresh_id, '0, 1'b0, 1'b0, wake, deadline, 1'b1);
                end
            end
            OP_CANCEL: begin
                // Cancel works even after stop.
                found = 1'b0;
                for (int unsigned i = 0; i < shadow_count && !found; i++) begin
                    if (shadow_id[i] == req.cancel_id) begin
                        drop_shadow_entry(i);
                        found = 1'b1;
                    end
                end
                owe_reply(KIND_CANCEL_ACK, '0, '0, found, 1'b0, 1'b0, '0, 1'b1);
            end
            OP_POP_ONE, OP_POP_ALL: begin
                if (shadow_stopped) begin
                    owe_reply(KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    // Fire due heads in order; pop-one fires at most one.
                    while (shadow_count > 0 && shadow_deadline[0] <= req.now_tick) begin
                        owe_reply(KIND_FIRED, shadow_id[0], shadow_handle[0], 1'b0, 1'b0,
                                  1'b0, '0, 1'b0);
                        drop_shadow_entry(0);
                        if (req.opcode == OP_POP_ONE)
                            break;
                    end
                    // Close with the wakeup for whatever now heads the queue.
                    owe_reply(KIND_DONE, '0, '0, 1'b0, 1'b0, shadow_count > 0,
                              shadow_deadline[0], 1'b1);
                end
            end
            OP_STOP: begin
                shadow_stopped = 1'b1;
                owe_reply(KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
            end
            default: begin
                owe_reply(KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic t_request make_request(logic [2:0] op, logic [63:0] now,
                                              logic [31:0] delay, logic [15:0] handle,
                                              logic [31:0] cid);
        t_request req;
        req.opcode      = op;
        req.now_tick    = now;
        req.delay_ticks = delay;
        req.task_handle = handle;
        req.cancel_id   = cid;
        return req;
    endfunction

    // Send one request: idle for the drawn gap, raise start, hold until the
    // block takes it. Keep start high when the next request follows at once,
    // so start never gets two assignments in one step.
    task automatic send_request(t_request req);
        repeat (next_gap) @(posedge i_clk);
        i_request <= req;
        if (!start_raised)
            start <= 1'b1;
        start_raised = 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        // Taken at this edge: predict before any reply can show up.
        update_shadow_queue(req);
        next_gap = $urandom_range(0, 9);
        if (next_gap != 0) begin
            start <= 1'b0;
            start_raised = 1'b0;
        end
    endtask

    // Drop start, wait for every owed reply, then let the block settle.
    task automatic wait_for_drain();
        if (start_raised)
            start <= 1'b0;
        start_raised = 1'b0;
        do
            @(posedge i_clk);
        while (owed_replies.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Check every strobed reply against the oldest owed one.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (owed_replies.size() == 0) begin
                report_mismatch("reply with nothing owed", 64'(o_result.kind), 64'd0);
            end else begin
                want = owed_replies.pop_front();
                compare_field("kind", 64'(o_result.kind), 64'(want.kind));
                compare_field("result_id", 64'(o_result.result_id), 64'(want.result_id));
                compare_field("fired_handle", 64'(o_result.fired_handle),
                              64'(want.fired_handle));
                compare_field("cancel_found", 64'(o_result.cancel_found),
                              64'(want.cancel_found));
                compare_field("queue_full", 64'(o_result.queue_full), 64'(want.queue_full));
                compare_field("wakeup_valid", 64'(o_result.wakeup_valid),
                              64'(want.wakeup_valid));
                compare_field("wakeup_time", o_result.wakeup_time, want.wakeup_time);
                compare_field("last", 64'(o_result.last), 64'(want.last));
            end
        end
    end

    // Empty queue right after reset: pops find nothing, cancel finds nothing,
    // an unused code is answered and ignored.
    task automatic test_empty_queue();
        send_request(make_request(OP_POP_ONE, '0, '0, '0, '0));
        send_request(make_request(OP_POP_ALL, TICK_MAX, '0, '0, '0));
        send_request(make_request(OP_CANCEL, '0, '0, '0, 32'd0));
        send_request(make_request(OP_LAST_UNUSED, TICK_MAX, DELAY_MAX, 16'hFFFF, '1));
        wait_for_drain();
    endtask

    // Posts at the tick extremes: saturation, an exact top deadline, and
    // equal deadlines ordered by id.
    task automatic test_post_ordering();
        logic [31:0] target;
        send_request(make_request(OP_POST, '0, '0, 16'h0000, '0));
        send_request(make_request(OP_POST, TICK_MAX, DELAY_MAX, 16'hFFFF, '0));
        send_request(make_request(OP_POST, TICK_MAX - 64'd5, 32'd5, 16'hA5A5, '0));
        send_request(make_request(OP_POST, 64'd100, '0, 16'h5A5A, '0));
        target = shadow_last_id;
        send_request(make_request(OP_POST, '0, '0, 16'h1234, '0));
        // Remove a middle entry, then miss on the same id.
        send_request(make_request(OP_CANCEL, '0, '0, '0, target));
        send_request(make_request(OP_CANCEL, '0, '0, '0, target));
        wait_for_drain();
    endtask

    // Pop-one fires just the head, pop-all fires every due entry, and a pop
    // with nothing due only reports the next wakeup.
    task automatic test_pop_due();
        send_request(make_request(OP_POP_ONE, '0, '0, '0, '0));
        send_request(make_request(OP_POP_ALL, 64'd50, '0, '0, '0));
        send_request(make_request(OP_POP_ONE, 64'd10, '0, '0, '0));
        wait_for_drain();
    endtask

    // Fill every slot, get refused once, then drain it all in one pop.
    task automatic test_full_queue();
        while (shadow_count < DEPTH)
            send_request(make_request(OP_POST, 64'd1000 + 64'($urandom_range(0, 99)),
                                      32'($urandom_range(0, 20)), 16'($urandom), '0));
        send_request(make_request(OP_POST, '0, '0, 16'hBEEF, '0));
        send_request(make_request(OP_POP_ALL, TICK_MAX, '0, '0, '0));
        wait_for_drain();
    endtask

    // Mostly well-formed traffic around a moving tick, with noise mixed in.
    task automatic test_random_traffic();
        logic [63:0] tick_base;
        t_request    req;
        int          pick;
        tick_base = {$urandom, $urandom};
        repeat (RANDOM_ITEMS) begin
            tick_base = tick_base + 64'($urandom_range(0, 20));
            pick = $urandom_range(0, 99);
            req  = make_request(OP_POST, tick_base, 32'($urandom_range(0, 60)),
                                16'($urandom), $urandom);
            if ($urandom_range(0, 19) == 0)
                req.now_tick = {$urandom, $urandom};
            if (pick < 40) begin
                if ($urandom_range(0, 7) == 0)
                    req.delay_ticks = $urandom;
            end else if (pick < 60) begin
                req.opcode = OP_CANCEL;
                // Aim mostly at live entries; keep random ids as misses.
                if (shadow_count > 0 && $urandom_range(0, 3) != 0)
                    req.cancel_id = shadow_id[$urandom_range(0, shadow_count - 1)];
            end else if (pick < 75) begin
                req.opcode = OP_POP_ONE;
            end else if (pick < 92) begin
                req.opcode = OP_POP_ALL;
            end else if (pick < 96) begin
                req.opcode   = OP_POP_ALL;
                req.now_tick = TICK_MAX;
            end else begin
                req.opcode = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            end
            send_request(req);
        end
        wait_for_drain();
    endtask

    // Stop blocks posts and pops for good but still lets cancel remove entries.
    // Run last: nothing brings the block back short of reset.
    task automatic test_stop();
        logic [31:0] target;
        send_request(make_request(OP_POST, 64'd200, 32'd5, 16'hC0DE, '0));
        target = shadow_last_id;
        send_request(make_request(OP_STOP, '0, '0, '0, '0));
        send_request(make_request(OP_POST, '0, '0, 16'hFFFF, '0));
        send_request(make_request(OP_POP_ONE, TICK_MAX, '0, '0, '0));
        send_request(make_request(OP_POP_ALL, TICK_MAX, '0, '0, '0));
        send_request(make_request(OP_CANCEL, '0, '0, '0, target));
        send_request(make_request(OP_CANCEL, '0, '0, '0, target));
        send_request(make_request(OP_STOP, TICK_MAX, DELAY_MAX, 16'hFFFF, '1));
        wait_for_drain();
    endtask

    // The id wrap past 2^32-1 is out of reach in one reset: it would take
    // four billion posts.
    initial begin
        next_gap = $urandom_range(0, 9);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue();
        test_post_ordering();
        test_pop_due();
        test_full_queue();
        test_random_traffic();
        test_stop();
        if (owed_replies.size() != 0)
            report_mismatch("replies never seen", 64'(owed_replies.size()), 64'd0);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/dotq_pkg.sv
src/dotq_cell.sv
src/deadline_ordered_timer_queue.sv
src/dotq_checker.sv
test/testbench.sv
